[hdl/eta_pkg.sv]
// Shared constants, payload types and state codes for the emissive triangle area block.
package eta_pkg;

  // Fixed-point format of coordinates and matrix factors.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int AREA_W    = 48;
  localparam int TOTAL_W   = 64;
  localparam int REG_W     = 64;
  localparam int ADDR_W    = 6;
  localparam int MAT_ROWS  = 3;
  localparam int NUM_REGS  = 7;

  // Transform arithmetic widths.
  localparam int PROD_W = 2 * COORD_W;
  localparam int XSUM_W = PROD_W + 2;

  // Cross product widths: edges, edge products, difference and magnitude.
  localparam int EDGE_W  = COORD_W + 1;
  localparam int EPROD_W = 2 * EDGE_W;
  localparam int DIFF_W  = EPROD_W + 1;
  localparam int MAG_W   = DIFF_W - FRAC_BITS;
  localparam int HALF_W  = (MAG_W + 1) / 2;
  localparam int MHI_W   = MAG_W - HALF_W;
  localparam int SSUM_W  = 2 * MAG_W + 2;

  // Square root sizing: a few root bits per cycle.
  localparam int SQ_STEPS  = 3;
  localparam int SQ_CYCLES = (SSUM_W / 2 + SQ_STEPS - 1) / SQ_STEPS;
  localparam int ROOT_W    = SQ_STEPS * SQ_CYCLES;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQCNT_W   = $clog2(SQ_CYCLES + 1);

  localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [REG_W-1:0]   FX_ONE    = REG_W'(1) << FRAC_BITS;

  // Register indexes.
  localparam logic [2:0] REG_ROW0_XY  = 3'd0;
  localparam logic [2:0] REG_ROW0_ZT  = 3'd1;
  localparam logic [2:0] REG_ROW1_XY  = 3'd2;
  localparam logic [2:0] REG_ROW1_ZT  = 3'd3;
  localparam logic [2:0] REG_ROW2_XY  = 3'd4;
  localparam logic [2:0] REG_ROW2_ZT  = 3'd5;
  localparam logic [2:0] REG_EMISSIVE = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    coord_t mx;
    coord_t my;
    coord_t mz;
    coord_t t;
  } row_t;

  typedef row_t [MAT_ROWS-1:0] mat_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    logic   final_triangle;
  } tri_in_t;

  typedef struct packed {
    coord_t              wa_x;
    coord_t              wa_y;
    coord_t              wa_z;
    coord_t              wb_x;
    coord_t              wb_y;
    coord_t              wb_z;
    coord_t              wc_x;
    coord_t              wc_y;
    coord_t              wc_z;
    logic [AREA_W-1:0]   tri_area;
    logic [TOTAL_W-1:0]  area_total;
    logic                is_final;
  } tri_out_t;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_XFORM = 8'b0000_0010,
    S_CROSS = 8'b0000_0100,
    S_MAG   = 8'b0000_1000,
    S_SQR   = 8'b0001_0000,
    S_SUM   = 8'b0010_0000,
    S_ROOT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

endpackage

[hdl/eta_lane.sv]
// Vertex lane: transforms one vertex by the model matrix, one row per cycle.
module eta_lane (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  eta_pkg::vtx_t                  vtx,
  input  eta_pkg::mat_t                  mat,
  output logic                           done,
  output eta_pkg::coord_t [eta_pkg::MAT_ROWS-1:0] w
);
  import eta_pkg::*;

  localparam logic [1:0] LAST_ROW = 2'(MAT_ROWS - 1);

  logic                     run;
  logic [1:0]               row;
  logic                     pv;
  logic [1:0]               prow;
  logic signed [PROD_W-1:0] p0, p1, p2;
  row_t                     cur;
  logic signed [XSUM_W-1:0] psum, shifted, wsum;
  coord_t                   wsat;

  assign cur = mat[row];

  // Row sequencer and pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      row  <= 2'd0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      pv   <= run;
      done <= pv && (prow == LAST_ROW);
      if (start) begin
        run <= 1'b1;
        row <= 2'd0;
      end else if (run) begin
        if (row == LAST_ROW) begin
          run <= 1'b0;
          row <= 2'd0;
        end else begin
          row <= row + 2'd1;
        end
      end
    end
  end

  // Three factor products for the current row.
  always_ff @(posedge clk) begin
    p0   <= cur.mx * vtx.x;
    p1   <= cur.my * vtx.y;
    p2   <= cur.mz * vtx.z;
    prow <= row;
    if (pv) begin
      w[prow] <= wsat;
    end
  end

  // Exact sum, floor of the fraction, translation, then saturation.
  always_comb begin
    psum = {{2{p0[PROD_W-1]}}, p0} + {{2{p1[PROD_W-1]}}, p1} + {{2{p2[PROD_W-1]}}, p2};
    shifted = psum >>> FRAC_BITS;
    wsum = shifted + {{(XSUM_W-COORD_W){mat[prow].t[COORD_W-1]}}, mat[prow].t};
    if (wsum > XSUM_W'(signed'(32'sh7FFF_FFFF))) begin
      wsat = 32'sh7FFF_FFFF;
    end else if (wsum < $signed({{(XSUM_W-COORD_W){1'b1}}, 32'h8000_0000})) begin
      wsat = 32'sh8000_0000;
    end else begin
      wsat = wsum[COORD_W-1:0];
    end
  end

endmodule

[hdl/eta_sqrt.sv]
// Iterative integer square root, several root bits per cycle.
module eta_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [eta_pkg::RAD_W-1:0]     radicand,
  output logic                          done,
  output logic [eta_pkg::ROOT_W-1:0]    root
);
  import eta_pkg::*;

  logic               busy;
  logic [SQCNT_W-1:0] cnt;
  logic [RAD_W-1:0]   n;
  logic [REM_W-1:0]   rem;
  logic [RAD_W-1:0]   n_next;
  logic [REM_W-1:0]   rem_next;
  logic [ROOT_W-1:0]  root_next;

  // Restoring steps: bring down two radicand bits, try the next root bit.
  always_comb begin
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    n_next    = n;
    rem_next  = rem;
    root_next = root;
    for (int i = 0; i < SQ_STEPS; i++) begin
      rs    = {rem_next[REM_W-3:0], n_next[RAD_W-1 -: 2]};
      trial = {root_next, 2'b01};
      n_next = n_next << 2;
      if (rs >= trial) begin
        rem_next  = rs - trial;
        root_next = {root_next[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = rs;
        root_next = {root_next[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SQCNT_W'(SQ_CYCLES);
      end else if (busy) begin
        cnt <= cnt - SQCNT_W'(1);
        if (cnt == SQCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      n    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      n    <= n_next;
      rem  <= rem_next;
      root <= root_next;
    end
  end

endmodule

[hdl/emissive_triangle_area.sv]
// Top level: config registers, vertex lanes, cross product merge, square root, running total.
// Flow: an accepted word passes the vertex lanes, the cross product, magnitude, square and
// sum states and the square root; its result word is then loaded into the output register.
// Throughput: one triangle at a time; the input stalls until that load, which waits while
// the output stalls; the square root iterations are the longest step. A disabled word is
// accepted without output. Reset: synchronous, active high; restores the identity matrix,
// clears emission enable, the area total and all handshake state. No clearing pass is needed.
module emissive_triangle_area (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  eta_pkg::tri_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output eta_pkg::tri_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eta_pkg::ADDR_W-1:0]  paddr,
  input  logic [eta_pkg::REG_W-1:0]   pwdata,
  output logic [eta_pkg::REG_W-1:0]   prdata,
  output logic                        pready
);
  import eta_pkg::*;

  state_t state;

  logic [REG_W-1:0] regs [0:5];
  logic             emissive;
  logic [2:0]       rix;
  mat_t             mat;

  logic [TOTAL_W-1:0] acc;
  logic               last;
  vtx_t               va, vb, vc;
  logic               lane_start;
  logic [2:0]         lane_done;
  coord_t [MAT_ROWS-1:0] wa, wb, wc;

  logic signed [EDGE_W-1:0]  e1 [0:2];
  logic signed [EDGE_W-1:0]  e2 [0:2];
  logic signed [EPROD_W-1:0] pr [0:5];
  logic [MAG_W-1:0]          m [0:2];
  logic [MAG_W-1:0]          m_next [0:2];
  logic [2*MHI_W-1:0]        sq_hh [0:2];
  logic [MAG_W-1:0]          sq_hl [0:2];
  logic [2*HALF_W-1:0]       sq_ll [0:2];
  logic [RAD_W-1:0]          rad;
  logic [RAD_W-1:0]          rad_next;
  logic                      sq_start;
  logic                      sq_done;
  logic [ROOT_W-1:0]         root;

  logic [AREA_W-1:0]  area;
  logic [TOTAL_W:0]   tsum;
  logic [TOTAL_W-1:0] total;
  logic               accept;
  logic               load;
  logic               cfg_wr;

  assign pready   = 1'b1;
  assign rix      = paddr[ADDR_W-1:3];
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = (state == S_OUT) && (!out_valid || !out_stall);

  // Matrix view of the register file.
  always_comb begin
    for (int r = 0; r < MAT_ROWS; r++) begin
      mat[r].mx = regs[2*r][31:0];
      mat[r].my = regs[2*r][63:32];
      mat[r].mz = regs[2*r+1][31:0];
      mat[r].t  = regs[2*r+1][63:32];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0]  <= FX_ONE;
      regs[1]  <= '0;
      regs[2]  <= FX_ONE << 32;
      regs[3]  <= '0;
      regs[4]  <= '0;
      regs[5]  <= FX_ONE;
      emissive <= 1'b0;
    end else if (cfg_wr) begin
      case (rix)
        REG_ROW0_XY:  regs[0]  <= pwdata;
        REG_ROW0_ZT:  regs[1]  <= pwdata;
        REG_ROW1_XY:  regs[2]  <= pwdata;
        REG_ROW1_ZT:  regs[3]  <= pwdata;
        REG_ROW2_XY:  regs[4]  <= pwdata;
        REG_ROW2_ZT:  regs[5]  <= pwdata;
        REG_EMISSIVE: emissive <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (rix)
      REG_ROW0_XY:  prdata = regs[0];
      REG_ROW0_ZT:  prdata = regs[1];
      REG_ROW1_XY:  prdata = regs[2];
      REG_ROW1_ZT:  prdata = regs[3];
      REG_ROW2_XY:  prdata = regs[4];
      REG_ROW2_ZT:  prdata = regs[5];
      REG_EMISSIVE: prdata = {{(REG_W-1){1'b0}}, emissive};
      default:      prdata = '0;
    endcase
  end

  // Capture of the input word.
  always_ff @(posedge clk) begin
    if (accept) begin
      va   <= '{x: in_data.a_x, y: in_data.a_y, z: in_data.a_z};
      vb   <= '{x: in_data.b_x, y: in_data.b_y, z: in_data.b_z};
      vc   <= '{x: in_data.c_x, y: in_data.c_y, z: in_data.c_z};
      last <= in_data.final_triangle;
    end
  end

  // One lane per vertex.
  eta_lane u_lane_a (.clk, .rst, .start(lane_start), .vtx(va), .mat, .done(lane_done[0]),
                     .w(wa));
  eta_lane u_lane_b (.clk, .rst, .start(lane_start), .vtx(vb), .mat, .done(lane_done[1]),
                     .w(wb));
  eta_lane u_lane_c (.clk, .rst, .start(lane_start), .vtx(vc), .mat, .done(lane_done[2]),
                     .w(wc));

  // Edge vectors from the saturated world positions.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e1[c] = {wb[c][COORD_W-1], wb[c]} - {wa[c][COORD_W-1], wa[c]};
      e2[c] = {wc[c][COORD_W-1], wc[c]} - {wa[c][COORD_W-1], wa[c]};
    end
  end

  // Cross component magnitudes with the fraction realigned.
  always_comb begin
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        mag;
    for (int k = 0; k < 3; k++) begin
      d   = {pr[2*k][EPROD_W-1], pr[2*k]} - {pr[2*k+1][EPROD_W-1], pr[2*k+1]};
      mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      m_next[k] = mag[DIFF_W-1:FRAC_BITS];
    end
  end

  // Sum of squares from the partial products.
  always_comb begin
    rad_next = '0;
    for (int k = 0; k < 3; k++) begin
      rad_next = rad_next + (RAD_W'(sq_hh[k]) << (2*HALF_W))
                          + (RAD_W'(sq_hl[k]) << (HALF_W+1))
                          + RAD_W'(sq_ll[k]);
    end
  end

  // Merge datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_CROSS) begin
      pr[0] <= e1[1] * e2[2];
      pr[1] <= e1[2] * e2[1];
      pr[2] <= e1[2] * e2[0];
      pr[3] <= e1[0] * e2[2];
      pr[4] <= e1[0] * e2[1];
      pr[5] <= e1[1] * e2[0];
    end
    if (state == S_MAG) begin
      for (int k = 0; k < 3; k++) m[k] <= m_next[k];
    end
    if (state == S_SQR) begin
      for (int k = 0; k < 3; k++) begin
        sq_hh[k] <= m[k][MAG_W-1:HALF_W] * m[k][MAG_W-1:HALF_W];
        sq_hl[k] <= m[k][MAG_W-1:HALF_W] * m[k][HALF_W-1:0];
        sq_ll[k] <= m[k][HALF_W-1:0] * m[k][HALF_W-1:0];
      end
    end
    if (state == S_SUM) begin
      rad <= rad_next;
    end
  end

  eta_sqrt u_sqrt (.clk, .rst, .start(sq_start), .radicand(rad), .done(sq_done), .root);

  // Area from the root, then the saturating total.
  always_comb begin
    if (root[ROOT_W-1:1] > (ROOT_W-1)'(AREA_MAX)) begin
      area = AREA_MAX;
    end else begin
      area = root[AREA_W:1];
    end
    tsum  = {1'b0, acc} + (TOTAL_W+1)'(area);
    total = tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
  end

  // Sequencer, accumulator and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc        <= '0;
      lane_start <= 1'b0;
      sq_start   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      lane_start <= 1'b0;
      sq_start   <= 1'b0;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (emissive) begin
              lane_start <= 1'b1;
              state      <= S_XFORM;
            end else if (in_data.final_triangle) begin
              acc <= '0;
            end
          end
        end
        S_XFORM: if (lane_done[0]) state <= S_CROSS;
        S_CROSS: state <= S_MAG;
        S_MAG:   state <= S_SQR;
        S_SQR:   state <= S_SUM;
        S_SUM: begin
          sq_start <= 1'b1;
          state    <= S_ROOT;
        end
        S_ROOT:  if (sq_done) state <= S_OUT;
        S_OUT: begin
          if (load) begin
            acc   <= last ? '0 : total;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.wa_x       <= wa[0];
      out_data.wa_y       <= wa[1];
      out_data.wa_z       <= wa[2];
      out_data.wb_x       <= wb[0];
      out_data.wb_y       <= wb[1];
      out_data.wb_z       <= wb[2];
      out_data.wc_x       <= wc[0];
      out_data.wc_y       <= wc[1];
      out_data.wc_z       <= wc[2];
      out_data.tri_area   <= area;
      out_data.area_total <= total;
      out_data.is_final   <= last;
    end
  end

  // The lanes finish together.
  a_lanes_together: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> (lane_done[1] && lane_done[2]))
    else $error("vertex lanes out of step");

  // The root finishes only while the sequencer waits for it.
  a_root_in_state: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_ROOT))
    else $error("square root done outside its state");

  // A delivered total always includes its own area.
  a_total_covers_area: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.area_total >= TOTAL_W'(out_data.tri_area)))
    else $error("area total below triangle area");

  // The total is cleared after the mesh's last triangle.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (load && last) |=> (acc == '0))
    else $error("total not cleared after last triangle");

endmodule
